[src/lru_key_order_tracker_assert.svh]
// ----------------------------------------------------------------------------
// LRU key order tracker - assertion macros
// Clocked, reset-qualified assertion wrappers used by the tracker control RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_ORDER_TRACKER_ASSERT_SVH
`define LRU_KEY_ORDER_TRACKER_ASSERT_SVH

// Check a property at every rising edge outside reset.
`define LRUT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define LRUT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LRUT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lrut_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key order tracker - package
// Sizes, operation codes and the control bundle that drives the cell row.
// ----------------------------------------------------------------------------
package lrut_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int MODE_W      = 2;

  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Row control driven to every cell
  typedef struct packed {
    logic cmp;    // latch per-cell match against the tag
    logic apply;  // rewrite the row
    logic evict;  // oldest entry leaves in this rewrite
  } cell_ctl_t;

endpackage

[src/lru_key_order_tracker.sv]
// ----------------------------------------------------------------------------
// LRU key order tracker - top level
// Recency-ordered list of key tags built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Pulse start_i with mode_i, key_i and backing_found_i while busy_o is low to
// transfer an operation. The result (hit_o, evicted_o, evicted_key_o,
// occupancy_o) appears for one cycle under done_o, registered at the end of
// the update phase; there is no back-pressure, so sample it when done_o is
// high. Each operation has a compare phase, where every cell compares its tag
// with the key in parallel, and an update phase, where the row shifts and
// appends (a flush only clears the count). A new operation may be transferred
// at the edge that ends the update cycle, so operations can run back to back.
// busy_o is high only in the compare cycle. Write active_capacity through
// cfg_we_i/cfg_data_i only while no operation is in flight; 0 acts as 1 and
// values above the row size act as the row size. Lowering it never drops keys
// at once: each later insertion evicts one oldest key. Cell contents past the
// occupancy hold stale data and are never matched.
// ----------------------------------------------------------------------------
module lru_key_order_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [lrut_pkg::CAP_W-1:0]    cfg_data_i,
  input  logic [lrut_pkg::MODE_W-1:0]   mode_i,
  input  logic [lrut_pkg::KEY_BITS-1:0] key_i,
  input  logic                          backing_found_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic [lrut_pkg::KEY_BITS-1:0] evicted_key_o,
  output logic [lrut_pkg::CNT_W-1:0]    occupancy_o
);
  import lrut_pkg::*;

  cell_ctl_t           ctl;
  logic [KEY_BITS-1:0] tag;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    tail_idx;
  logic [KEY_BITS-1:0] evk;

  // Per-cell row signals; index 0 is the oldest entry
  logic [KEY_BITS-1:0]    key_w   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_w;
  logic [MAX_ENTRIES-1:0] hb_w;
  logic [MAX_ENTRIES-1:0] live_w;
  logic [MAX_ENTRIES-1:0] tail_w;

  lrut_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .key_i           (key_i),
    .backing_found_i (backing_found_i),
    .match_any_i     (|match_w),
    .evk_i           (evk),
    .ctl_o           (ctl),
    .tag_o           (tag),
    .count_o         (count),
    .tail_o          (tail_idx),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .evicted_o       (evicted_o),
    .evicted_key_o   (evicted_key_o),
    .occupancy_o     (occupancy_o)
  );

  // A hit in the oldest slot is dropped first, so the eviction takes slot one
  assign evk = match_w[0] ? key_w[1] : key_w[0];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                hb_prev;
    logic                match_next;
    logic [KEY_BITS-1:0] key_n1, key_n2;

    assign live_w[i] = (CNT_W'(i) < count);
    assign tail_w[i] = (tail_idx == IDX_W'(i));

    if (i == 0) begin : g_first
      assign hb_prev = 1'b0;
    end else begin : g_inner
      assign hb_prev = hb_w[i-1];
    end

    if (i + 1 < MAX_ENTRIES) begin : g_n1
      assign match_next = match_w[i+1];
      assign key_n1     = key_w[i+1];
    end else begin : g_n1_end
      assign match_next = 1'b0;
      assign key_n1     = '0;
    end

    if (i + 2 < MAX_ENTRIES) begin : g_n2
      assign key_n2 = key_w[i+2];
    end else begin : g_n2_end
      assign key_n2 = '0;
    end

    lrut_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .tag_i        (tag),
      .live_i       (live_w[i]),
      .tail_i       (tail_w[i]),
      .hb_prev_i    (hb_prev),
      .match_next_i (match_next),
      .key_n1_i     (key_n1),
      .key_n2_i     (key_n2),
      .key_o        (key_w[i]),
      .match_o      (match_w[i]),
      .hb_o         (hb_w[i])
    );
  end

endmodule

[src/lrut_cell.sv]
// ----------------------------------------------------------------------------
// LRU key order tracker - list cell
// Holds one key tag, compares it with the lookup tag and takes its new tag
// from itself, from one of its two upper neighbors, or from the lookup tag.
// ----------------------------------------------------------------------------
module lrut_cell (
  input  logic                          clk_i,
  input  lrut_pkg::cell_ctl_t           ctl_i,
  input  logic [lrut_pkg::KEY_BITS-1:0] tag_i,
  input  logic                          live_i,
  input  logic                          tail_i,
  input  logic                          hb_prev_i,
  input  logic                          match_next_i,
  input  logic [lrut_pkg::KEY_BITS-1:0] key_n1_i,
  input  logic [lrut_pkg::KEY_BITS-1:0] key_n2_i,
  output logic [lrut_pkg::KEY_BITS-1:0] key_o,
  output logic                          match_o,
  output logic                          hb_o
);
  import lrut_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                match_q;
  logic                match_d;

  assign match_d = live_i && (key_q == tag_i);
  // Hit at or below this cell
  assign hb_o    = hb_prev_i | match_q;

  always_comb begin
    if (tail_i) begin
      key_d = tag_i;
    end else if (ctl_i.evict) begin
      key_d = (hb_o | match_next_i) ? key_n2_i : key_n1_i;
    end else if (hb_o) begin
      key_d = key_n1_i;
    end else begin
      key_d = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.apply) begin
      key_q <= key_d;
    end
    if (ctl_i.cmp) begin
      match_q <= match_d;
    end
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule

[src/lrut_ctrl.sv]
// ----------------------------------------------------------------------------
// LRU key order tracker - control
// Sequences compare and update, keeps the entry count and the capacity
// register, and registers the result.
// ----------------------------------------------------------------------------
module lrut_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [lrut_pkg::CAP_W-1:0]    cfg_data_i,
  input  logic [lrut_pkg::MODE_W-1:0]   mode_i,
  input  logic [lrut_pkg::KEY_BITS-1:0] key_i,
  input  logic                          backing_found_i,
  input  logic                          match_any_i,
  input  logic [lrut_pkg::KEY_BITS-1:0] evk_i,
  output lrut_pkg::cell_ctl_t           ctl_o,
  output logic [lrut_pkg::KEY_BITS-1:0] tag_o,
  output logic [lrut_pkg::CNT_W-1:0]    count_o,
  output logic [lrut_pkg::IDX_W-1:0]    tail_o,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic [lrut_pkg::KEY_BITS-1:0] evicted_key_o,
  output logic [lrut_pkg::CNT_W-1:0]    occupancy_o
);
  import lrut_pkg::*;

  `include "lru_key_order_tracker_assert.svh"

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_UPD  = 2'd2;

  logic [1:0]          phase_q, phase_d;
  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [MODE_W-1:0]   mode_q;
  logic [KEY_BITS-1:0] tag_q;
  logic                found_q;
  logic                done_q;
  logic                hit_q, evicted_q;
  logic [KEY_BITS-1:0] evk_q;
  logic [CNT_W-1:0]    occ_q;

  logic                accept;
  logic                upd;
  logic                is_set, is_get, is_flush;
  logic                hit_eff, ins, apply, evict;
  logic [CNT_W-1:0]    eff_cap, n1, n_f;

  assign busy_o = (phase_q == PH_CMP);
  assign accept = start_i && !busy_o;
  assign upd    = (phase_q == PH_UPD);

  assign is_set   = (mode_q == MODE_SET);
  assign is_get   = (mode_q == MODE_GET);
  assign is_flush = (mode_q == MODE_FLUSH);

  // Clamp capacity to 1..MAX_ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign hit_eff = match_any_i && (is_set || is_get);
  assign ins     = is_set || (is_get && !match_any_i && found_q);
  assign apply   = is_set || (is_get && (match_any_i || found_q));
  assign n1      = count_q - CNT_W'(hit_eff);
  assign evict   = ins && (n1 >= eff_cap) && (n1 != '0);

  always_comb begin
    if (apply) begin
      n_f = n1 - CNT_W'(evict) + CNT_W'(1);
    end else if (is_flush) begin
      n_f = '0;
    end else begin
      n_f = count_q;
    end
  end

  assign count_d = upd ? n_f : count_q;

  always_comb begin
    case (phase_q)
      PH_IDLE: phase_d = accept ? PH_CMP : PH_IDLE;
      PH_CMP:  phase_d = PH_UPD;
      PH_UPD:  phase_d = accept ? PH_CMP : PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cap_q   <= CAP_RESET;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      done_q  <= upd;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Hold the item for compare and update; latch the result on update
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      tag_q   <= key_i;
      found_q <= backing_found_i;
    end
    if (upd) begin
      hit_q     <= hit_eff;
      evicted_q <= evict;
      evk_q     <= evict ? evk_i : '0;
      occ_q     <= n_f;
    end
  end

  assign ctl_o.cmp   = (phase_q == PH_CMP);
  assign ctl_o.apply = upd && apply;
  assign ctl_o.evict = evict;
  assign tag_o       = tag_q;
  assign count_o     = count_q;
  assign tail_o      = IDX_W'(n_f - CNT_W'(1));

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evk_q;
  assign occupancy_o   = occ_q;

  `LRUT_ASSERT(a_count_max, count_q <= CNT_W'(MAX_ENTRIES), "entry count above row size")
  `LRUT_ASSERT_NEXT(a_cmp_then_upd, phase_q == PH_CMP, phase_q == PH_UPD, "compare not followed by update")
  `LRUT_ASSERT_NEXT(a_done_after_upd, phase_q == PH_UPD, done_q, "update without result strobe")
  `LRUT_ASSERT_NEXT(a_no_stray_done, phase_q != PH_UPD, !done_q, "result strobe without update")
  `LRUT_ASSERT_IMPL(a_evk_zero, done_q && !evicted_q, evk_q == '0, "evicted key not zero")

endmodule
